// File: hw/rtl/iir_pkg.sv
// shared types, constants and coefficient rom for the order six iir filter
package iir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 40;
  localparam int ROM_IDX_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic acc_clear;
    logic issue;
    logic done;
  } ctrl_t;

  // feedforward taps b[k] in q2.15
  function automatic logic signed [COEF_W-1:0] ff_coef(input logic [ROM_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    unique case (k)
      5'd0:    c = 18'sd249;
      5'd1:    c = 18'sd1491;
      5'd2:    c = 18'sd3728;
      5'd3:    c = 18'sd4971;
      5'd4:    c = 18'sd3728;
      5'd5:    c = 18'sd1491;
      5'd6:    c = 18'sd249;
      default: c = '0;
    endcase
    return c;
  endfunction

  // feedback taps stored negated so the mac only ever adds
  function automatic logic signed [COEF_W-1:0] fb_neg_coef(input logic [ROM_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    unique case (k)
      5'd0:    c = 18'sd48662;
      5'd1:    c = -18'sd52547;
      5'd2:    c = 18'sd30280;
      5'd3:    c = -18'sd11771;
      5'd4:    c = 18'sd2478;
      5'd5:    c = -18'sd240;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/iir_filter_order6.sv
// top level of the order six direct form i iir filter with one shared mac
//
//   channel | signals                          | beat
//   --------+----------------------------------+---------------------------
//   input   | in_valid, in_ready, sample_in    | one q1.15 sample x[n]
//   output  | out_valid, out_ready, sample_out | one q1.15 sample y[n]
//
// each sample runs through an accept step, one mac issue per tap, a drain step
// for the product register and a finish step that rounds, saturates and loads
// the output register.
// in_ready is high only while the sequencer is idle; a result held by a
// stalled output stays put while the next sample is taken, and the new
// result waits in the finish step until the output register is free.
// reset clears both sample histories and the handshake state.
module iir_filter_order6 #(
  parameter int NUM_FEEDFORWARD = 7,
  parameter int NUM_FEEDBACK    = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [iir_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iir_pkg::SAMPLE_W-1:0] sample_out
);

  localparam int NUM_TAPS = NUM_FEEDFORWARD + NUM_FEEDBACK;
  localparam int TAP_W    = $clog2(NUM_TAPS);
  localparam int XW       = (NUM_FEEDFORWARD > 1) ? $clog2(NUM_FEEDFORWARD) : 1;
  localparam int YW       = (NUM_FEEDBACK > 1) ? $clog2(NUM_FEEDBACK) : 1;
  localparam int SW       = iir_pkg::SAMPLE_W;

  iir_pkg::ctrl_t             ctrl;
  logic [TAP_W-1:0]           tap;
  logic [TAP_W-1:0]           fb_tap;
  logic                       out_free;
  logic signed [SW-1:0]       x_hist [NUM_FEEDFORWARD];
  logic signed [SW-1:0]       y_hist [NUM_FEEDBACK];
  logic signed [SW-1:0]       mac_data;
  logic signed [iir_pkg::COEF_W-1:0] mac_coef;
  logic signed [iir_pkg::ACC_W-1:0]  acc;
  logic signed [iir_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [SW-1:0]       y;

  assign out_free = !out_valid || out_ready;
  assign in_ready = ctrl.ready;

  iir_ctrl #(.NUM_TAPS(NUM_TAPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl),
    .tap      (tap)
  );

  // entry 0 holds the current sample while the taps run
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FEEDFORWARD; i++) x_hist[i] <= '0;
    end else if (ctrl.accept) begin
      x_hist[0] <= sample_in;
      for (int i = 1; i < NUM_FEEDFORWARD; i++) x_hist[i] <= x_hist[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FEEDBACK; i++) y_hist[i] <= '0;
    end else if (ctrl.done) begin
      y_hist[0] <= y;
      for (int i = 1; i < NUM_FEEDBACK; i++) y_hist[i] <= y_hist[i-1];
    end
  end

  // operand select: feedforward taps first, then feedback taps
  assign fb_tap = tap - TAP_W'(NUM_FEEDFORWARD);

  always_comb begin
    if (tap < TAP_W'(NUM_FEEDFORWARD)) begin
      mac_data = x_hist[tap[XW-1:0]];
      mac_coef = iir_pkg::ff_coef(iir_pkg::ROM_IDX_W'(tap));
    end else begin
      mac_data = y_hist[fb_tap[YW-1:0]];
      mac_coef = iir_pkg::fb_neg_coef(iir_pkg::ROM_IDX_W'(fb_tap));
    end
  end

  iir_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (ctrl.acc_clear),
    .issue (ctrl.issue),
    .coef  (mac_coef),
    .data  (mac_data),
    .acc   (acc)
  );

  // round half up, then clamp when bits above q1.15 disagree with the sign
  assign acc_rnd = acc + iir_pkg::ACC_W'(1 << 14);

  always_comb begin
    if (acc_rnd[iir_pkg::ACC_W-1:30] == '0 || acc_rnd[iir_pkg::ACC_W-1:30] == '1) begin
      y = acc_rnd[30:15];
    end else if (acc_rnd[iir_pkg::ACC_W-1]) begin
      y = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      sample_out <= y;
    end
  end

endmodule

// File: hw/rtl/iir_mac.sv
// shared multiply-accumulate unit: registered product, then 40-bit accumulator
module iir_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 issue,
  input  logic signed [iir_pkg::COEF_W-1:0]    coef,
  input  logic signed [iir_pkg::SAMPLE_W-1:0]  data,
  output logic signed [iir_pkg::ACC_W-1:0]     acc
);

  logic signed [iir_pkg::PROD_W-1:0] prod;
  logic                              prod_valid;

  always_ff @(posedge clk) begin
    prod <= coef * data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + iir_pkg::ACC_W'(prod);
    end
  end

endmodule

// File: hw/rtl/iir_ctrl.sv
// sequencer that steps the shared mac through all taps of one sample
module iir_ctrl #(
  parameter int NUM_TAPS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         out_free,
  output iir_pkg::ctrl_t               ctrl,
  output logic [$clog2(NUM_TAPS)-1:0]  tap
);

  localparam int TAP_W = $clog2(NUM_TAPS);

  iir_pkg::state_t  state, state_next;
  logic [TAP_W-1:0] cnt, cnt_next;
  logic             last_tap;

  assign last_tap = (cnt == TAP_W'(NUM_TAPS - 1));
  assign tap      = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iir_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iir_pkg::ST_IDLE:   if (in_valid) state_next = iir_pkg::ST_RUN;
      iir_pkg::ST_RUN:    if (last_tap) state_next = iir_pkg::ST_DRAIN;
      iir_pkg::ST_DRAIN:  state_next = iir_pkg::ST_FINISH;
      iir_pkg::ST_FINISH: if (out_free) state_next = iir_pkg::ST_IDLE;
      default:            state_next = iir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    cnt_next = '0;
    unique case (state)
      iir_pkg::ST_IDLE: begin
        ctrl.ready     = 1'b1;
        ctrl.accept    = in_valid;
        ctrl.acc_clear = in_valid;
      end
      iir_pkg::ST_RUN: begin
        ctrl.issue = 1'b1;
        cnt_next   = last_tap ? '0 : cnt + 1'b1;
      end
      iir_pkg::ST_DRAIN: begin
        ctrl.issue = 1'b0;
      end
      iir_pkg::ST_FINISH: begin
        ctrl.done = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/iir_filter_order6_chk.sv
// port-level checker for the iir filter, bound to the top level
module iir_filter_order6_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] sample_in,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample_out
);

  // a stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("output beat changed while stalled");

  // the filter is busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an input beat");

  // no result can appear the cycle after an input beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // ready only drops because a sample was taken
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("ready dropped without an input beat");

  // a new result comes out as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while sequencer busy");

endmodule

bind iir_filter_order6 iir_filter_order6_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .sample_in  (sample_in),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

// File: verif/iir_filter_order6_checker.sv
// scoreboard for the order six iir filter: tracks the filter state, predicts and compares each beat
module iir_filter_order6_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [iir_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [iir_pkg::SAMPLE_W-1:0] sample_out,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  samples_in,
  output int                                  results_checked,
  output int                                  saturated
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FF = 7;
  localparam int NUM_FB = 6;

  // b[k] and a[k] in q2.15
  localparam logic signed [iir_pkg::COEF_W-1:0] FF_TAPS [NUM_FF] = '{
    18'sd249, 18'sd1491, 18'sd3728, 18'sd4971, 18'sd3728, 18'sd1491, 18'sd249
  };
  localparam logic signed [iir_pkg::COEF_W-1:0] FB_TAPS [NUM_FB] = '{
    -18'sd48662, 18'sd52547, -18'sd30280, 18'sd11771, -18'sd2478, 18'sd240
  };

  localparam logic signed [iir_pkg::ACC_W-1:0] HALF_LSB = 40'sd16384;
  localparam logic signed [iir_pkg::ACC_W-1:0] Q15_MAX  = 40'sd32767;
  localparam logic signed [iir_pkg::ACC_W-1:0] Q15_MIN  = -40'sd32768;

  // x_hist[0] is the current sample during a prediction, y_hist[k] is y[n-1-k]
  logic signed [iir_pkg::SAMPLE_W-1:0] x_hist [NUM_FF];
  logic signed [iir_pkg::SAMPLE_W-1:0] y_hist [NUM_FB];
  logic signed [iir_pkg::SAMPLE_W-1:0] expected_out [$];
  logic signed [iir_pkg::SAMPLE_W-1:0] predicted, oldest;

  initial begin
    fail_count      = 0;
    pending         = 0;
    samples_in      = 0;
    results_checked = 0;
    saturated       = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic signed [iir_pkg::SAMPLE_W-1:0] filter_next(
    input logic signed [iir_pkg::SAMPLE_W-1:0] x
  );
    logic signed [iir_pkg::ACC_W-1:0]    acc, tap, smp, rounded;
    logic signed [iir_pkg::SAMPLE_W-1:0] y;
    for (int k = NUM_FF - 1; k > 0; k--) x_hist[k] = x_hist[k-1];
    x_hist[0] = x;
    acc = '0;
    for (int k = 0; k < NUM_FF; k++) begin
      tap = FF_TAPS[k];
      smp = x_hist[k];
      acc += tap * smp;
    end
    for (int k = 0; k < NUM_FB; k++) begin
      tap = FB_TAPS[k];
      smp = y_hist[k];
      acc -= tap * smp;
    end
    // round half up, then clamp to q1.15
    rounded = (acc + HALF_LSB) >>> 15;
    if (rounded > Q15_MAX) y = 16'sh7fff;
    else if (rounded < Q15_MIN) y = 16'sh8000;
    else y = rounded[iir_pkg::SAMPLE_W-1:0];
    for (int k = NUM_FB - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
    y_hist[0] = y;
    return y;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_FF; k++) x_hist[k] = '0;
      for (int k = 0; k < NUM_FB; k++) y_hist[k] = '0;
      expected_out.delete();
    end else begin
      if (in_valid && in_ready) begin
        predicted = filter_next(sample_in);
        expected_out.push_back(predicted);
        samples_in++;
        if (predicted == 16'sh7fff || predicted == 16'sh8000) saturated++;
      end
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with nothing outstanding", sample_out));
        end else begin
          oldest = expected_out.pop_front();
          results_checked++;
          if (sample_out !== oldest)
            report_mismatch($sformatf("result %0d: sample_out %0d, predicted %0d",
                                      results_checked, sample_out, oldest));
        end
      end
    end
    pending <= expected_out.size();
  end

endmodule

// File: verif/testbench.sv
// top of the order six iir filter bench: clock, reset, sample stimulus, ready pattern and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BEATS = 800;
  localparam int DRAIN_CYCLES = 40;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                out_ready = 1'b0;
  logic signed [iir_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic                                in_ready;
  logic                                out_valid;
  logic signed [iir_pkg::SAMPLE_W-1:0] sample_out;

  int send_idle_pct = 21;
  int recv_idle_pct = 69;
  int cycles        = 0;
  int fail_count, pending, samples_in, results_checked, saturated;

  always #6 clk = ~clk;

  iir_filter_order6 u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  iir_filter_order6_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_in       (sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_out      (sample_out),
    .fail_count      (fail_count),
    .pending         (pending),
    .samples_in      (samples_in),
    .results_checked (results_checked),
    .saturated       (saturated)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAIL iir_filter_order6");
      $finish;
    end
  end

  // present one sample and hold it until the beat is taken; returns at a falling edge
  task automatic send_sample(input logic signed [iir_pkg::SAMPLE_W-1:0] s);
    // each cycle the sender may hold off before offering the beat
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int                                  sent, run_len, kind;
    logic signed [iir_pkg::SAMPLE_W-1:0] level;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 21; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        // impulse at full scale
        send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh0000);
        // full-scale steps overshoot into both clamps
        repeat (8) send_sample(16'sh8000);
        repeat (6) send_sample(16'sh7fff);
      end

      sent = 0;
      while (sent < RANDOM_BEATS / 3) begin
        kind    = $urandom_range(0, 9);
        run_len = $urandom_range(1, 12);
        level   = iir_pkg::SAMPLE_W'($urandom);
        repeat (run_len) begin
          unique case (kind)
            0, 1, 2, 3: send_sample(iir_pkg::SAMPLE_W'($urandom));
            4, 5:       send_sample(level);
            6:          send_sample($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
            7:          send_sample(iir_pkg::SAMPLE_W'($urandom_range(0, 1023)) - 16'sd512);
            8: begin
              send_sample(level);
              level = ~level;
            end
            default:    send_sample(level + iir_pkg::SAMPLE_W'($urandom_range(0, 64))
                                    - 16'sd32);
          endcase
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0 || out_valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples filtered, %0d results checked, %0d of them clamped at full scale",
             samples_in, results_checked, saturated);
    $display("stimulus: extremes, impulse and steps, then random bursts under three stall mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS iir_filter_order6");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("FAIL iir_filter_order6");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/iir_pkg.sv
hw/rtl/iir_mac.sv
hw/rtl/iir_ctrl.sv
hw/rtl/iir_filter_order6.sv
hw/rtl/iir_filter_order6_chk.sv
verif/iir_filter_order6_checker.sv
verif/testbench.sv
